/* hdl/u8dec_pkg.sv */
package u8dec_pkg;

   localparam int ByteWidth = 8;
   localparam int CpWidth   = 21;
   localparam int HoldDepth = 3;

   localparam logic [CpWidth-1:0] ReplacementCp = 21'h00fffd;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [CpWidth-1:0]   cp_type;
   typedef logic [1:0]           count_type;
   typedef logic [2:0]           len_type;

   localparam len_type LenInvalid = 3'd0;
   localparam len_type LenOne     = 3'd1;
   localparam len_type LenTwo     = 3'd2;
   localparam len_type LenThree   = 3'd3;
   localparam len_type LenFour    = 3'd4;

   // Sequence length announced by a lead byte; zero for continuation bytes and F8-FF.
   function automatic len_type lead_length(input byte_type b);
      len_type len;
      if (b[7] == 1'b0) begin
         len = LenOne;
      end else if ((b & 8'he0) == 8'hc0) begin
         len = LenTwo;
      end else if ((b & 8'hf0) == 8'he0) begin
         len = LenThree;
      end else if ((b & 8'hf8) == 8'hf0) begin
         len = LenFour;
      end else begin
         len = LenInvalid;
      end
      return len;
   endfunction

endpackage

/* hdl/u8dec_req_if.sv */
interface u8dec_req_if;
   import u8dec_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

/* hdl/u8dec_rsp_if.sv */
interface u8dec_rsp_if;
   import u8dec_pkg::*;

   logic   valid;
   logic   ready;
   cp_type codepoint;
   logic   replaced;
   logic   run_last;

   modport source (output valid, output codepoint, output replaced, output run_last,
                   input ready);
   modport sink   (input valid, input codepoint, input replaced, input run_last,
                   output ready);
endinterface

/* hdl/utf8_codepoint_decoder.sv */
// The first result word of an input byte appears in the cycle after the byte is taken.
// One byte per cycle while each byte gives at most one word and the result side takes it;
// a byte that gives n words holds the single result register, and new input waits until
// the last of them is taken. Reset (synchronous, active high) empties the result register
// and drops any partly received sequence; the held byte buffer itself is not cleared.
module utf8_codepoint_decoder (
   input logic  clock,
   input logic  reset,
   u8dec_req_if.sink   req_ch,
   u8dec_rsp_if.source rsp_ch
);
   import u8dec_pkg::*;

   // Decoder state.
   count_type pend_count_ff, pend_count_in;
   len_type   exp_len_ff, exp_len_in;
   byte_type  pend_bytes_ff [HoldDepth];
   logic      wr_en;
   count_type wr_idx;

   // Result register: a burst of replacement words followed by an optional final word.
   count_type rep_left_ff, rep_left_in;
   logic      fin_valid_ff, fin_valid_in;
   cp_type    fin_cp_ff, fin_cp_in;
   logic      fin_rep_ff, fin_rep_in;

   // Burst produced by the byte at the input.
   count_type rep_n;
   logic      fin_v;
   cp_type    fin_cp;
   logic      fin_rep;

   logic      busy;
   logic      rsp_fire;
   logic      last_beat;
   logic      req_fire;
   logic      is_cont;
   len_type   new_len;
   cp_type    assembled;
   byte_type  b;

   assign b         = req_ch.data_byte;
   assign busy      = (rep_left_ff != 2'd0) || fin_valid_ff;
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign last_beat = rsp_fire && rsp_ch.run_last;
   assign req_ch.ready = !busy || last_beat;
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign is_cont   = (b[7:6] == 2'b10);
   assign new_len   = lead_length(b);

   always_comb begin
      case (exp_len_ff)
         LenTwo:   assembled = {10'd0, pend_bytes_ff[0][4:0], b[5:0]};
         LenThree: assembled = {5'd0, pend_bytes_ff[0][3:0], pend_bytes_ff[1][5:0], b[5:0]};
         default:  assembled = {pend_bytes_ff[0][2:0], pend_bytes_ff[1][5:0],
                                pend_bytes_ff[2][5:0], b[5:0]};
      endcase
   end

   always_comb begin
      pend_count_in = pend_count_ff;
      exp_len_in    = exp_len_ff;
      wr_en         = 1'b0;
      wr_idx        = pend_count_ff;
      rep_n         = 2'd0;
      fin_v         = 1'b0;
      fin_cp        = {13'd0, b};
      fin_rep       = 1'b0;
      if ((pend_count_ff != 2'd0) && is_cont) begin
         if ({1'b0, pend_count_ff} + 3'd1 == exp_len_ff) begin
            fin_v         = 1'b1;
            fin_cp        = assembled;
            pend_count_in = 2'd0;
            exp_len_in    = LenInvalid;
         end else if (!req_ch.stream_end) begin
            wr_en         = 1'b1;
            pend_count_in = pend_count_ff + 2'd1;
         end else begin
            // Stream ends mid-sequence: every held byte and this one are replaced.
            rep_n         = pend_count_ff;
            fin_v         = 1'b1;
            fin_cp        = ReplacementCp;
            fin_rep       = 1'b1;
            pend_count_in = 2'd0;
            exp_len_in    = LenInvalid;
         end
      end else begin
         // Any held bytes were cut short; the current byte is decoded afresh.
         rep_n         = pend_count_ff;
         pend_count_in = 2'd0;
         exp_len_in    = LenInvalid;
         if (new_len == LenOne) begin
            fin_v = 1'b1;
         end else if ((new_len != LenInvalid) && !req_ch.stream_end) begin
            wr_en         = 1'b1;
            wr_idx        = 2'd0;
            pend_count_in = 2'd1;
            exp_len_in    = new_len;
         end else begin
            fin_v   = 1'b1;
            fin_cp  = ReplacementCp;
            fin_rep = 1'b1;
         end
      end
   end

   always_comb begin
      rep_left_in  = rep_left_ff;
      fin_valid_in = fin_valid_ff;
      fin_cp_in    = fin_cp_ff;
      fin_rep_in   = fin_rep_ff;
      if (rsp_fire) begin
         if (rep_left_ff != 2'd0) begin
            rep_left_in = rep_left_ff - 2'd1;
         end else begin
            fin_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         rep_left_in  = rep_n;
         fin_valid_in = fin_v;
         fin_cp_in    = fin_cp;
         fin_rep_in   = fin_rep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_count_ff <= 2'd0;
         exp_len_ff    <= LenInvalid;
         rep_left_ff   <= 2'd0;
         fin_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            pend_count_ff <= pend_count_in;
            exp_len_ff    <= exp_len_in;
         end
         rep_left_ff  <= rep_left_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_cp_ff  <= fin_cp_in;
      fin_rep_ff <= fin_rep_in;
      if (req_fire && wr_en) begin
         pend_bytes_ff[wr_idx] <= b;
      end
   end

   assign rsp_ch.valid     = busy;
   assign rsp_ch.codepoint = (rep_left_ff != 2'd0) ? ReplacementCp : fin_cp_ff;
   assign rsp_ch.replaced  = (rep_left_ff != 2'd0) ? 1'b1 : fin_rep_ff;
   assign rsp_ch.run_last  = (rep_left_ff != 2'd0) ? ((rep_left_ff == 2'd1) && !fin_valid_ff)
                                                   : 1'b1;

   // A held sequence is always shorter than the length its lead announced.
   a_pend_below_len: assert property (@(posedge clock) disable iff (reset)
      (pend_count_ff != 2'd0) |-> ({1'b0, pend_count_ff} < exp_len_ff))
      else $error("held byte count not below expected length");

   // No sequence is open while nothing is held.
   a_idle_no_len: assert property (@(posedge clock) disable iff (reset)
      (pend_count_ff == 2'd0) |-> (exp_len_ff == LenInvalid))
      else $error("expected length set with no held bytes");

   // The last byte of a text never leaves a sequence open.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.stream_end) |=> (pend_count_ff == 2'd0))
      else $error("sequence still held after stream end");

   // Words of a replacement burst ahead of the final word carry the replacement code.
   a_burst_fffd: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.run_last) |-> (rsp_ch.replaced &&
                                               rsp_ch.codepoint == ReplacementCp))
      else $error("non-final word of a burst is not a replacement");

endmodule

/* tb/sv/u8dec_decode_checker.sv */
module u8dec_decode_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  u8dec_pkg::byte_type req_byte,
   input  logic                req_end,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  u8dec_pkg::cp_type   rsp_codepoint,
   input  logic                rsp_replaced,
   input  logic                rsp_run_last,
   output int                  mismatches,
   output int                  words_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import u8dec_pkg::*;

   typedef struct packed {
      cp_type codepoint;
      logic   replaced;
      logic   run_last;
   } cp_word_type;

   cp_word_type codepoints_due[$];
   byte_type    held_bytes[HoldDepth];
   count_type   held_count;
   len_type     seq_len;
   int          error_count = 0;
   int          due_count = 0;

   assign mismatches = error_count;
   assign words_due  = due_count;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic len_type announced_len(input byte_type b);
      len_type len;
      casez (b)
         8'b0???????: len = LenOne;
         8'b110?????: len = LenTwo;
         8'b1110????: len = LenThree;
         8'b11110???: len = LenFour;
         default:     len = LenInvalid;
      endcase
      return len;
   endfunction

   // Works out the words that one accepted byte causes and queues them in order.
   function automatic void decode_byte(input byte_type b, input logic last);
      cp_word_type words[4];
      int          n;
      int          k;
      cp_type      acc;
      len_type     len;
      n = 0;
      if (held_count != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            if ({1'b0, held_count} + 3'd1 == seq_len) begin
               case (seq_len)
                  LenTwo:   acc = cp_type'(held_bytes[0][4:0]);
                  LenThree: acc = cp_type'(held_bytes[0][3:0]);
                  default:  acc = cp_type'(held_bytes[0][2:0]);
               endcase
               for (k = 1; k < int'(held_count); k++) begin
                  acc = (acc << 6) | cp_type'(held_bytes[k][5:0]);
               end
               acc = (acc << 6) | cp_type'(b[5:0]);
               held_count = 2'd0;
               seq_len = LenInvalid;
               codepoints_due.push_back('{acc, 1'b0, 1'b1});
               return;
            end
            if (!last && held_count < 2'd3) begin
               held_bytes[held_count] = b;
               held_count = held_count + 2'd1;
               return;
            end
         end
         // The sequence was cut short: every held byte becomes a replacement.
         for (k = 0; k < int'(held_count); k++) begin
            words[n] = '{ReplacementCp, 1'b1, 1'b0};
            n++;
         end
         held_count = 2'd0;
         seq_len = LenInvalid;
      end
      len = announced_len(b);
      if (len == LenOne) begin
         words[n] = '{cp_type'(b), 1'b0, 1'b0};
         n++;
      end else if (len != LenInvalid && !last) begin
         held_bytes[0] = b;
         held_count = 2'd1;
         seq_len = len;
      end else begin
         words[n] = '{ReplacementCp, 1'b1, 1'b0};
         n++;
      end
      for (k = 0; k < n; k++) begin
         words[k].run_last = (k == n - 1);
         codepoints_due.push_back(words[k]);
      end
   endfunction

   always @(posedge clock) begin
      cp_word_type want;
      if (reset) begin
         codepoints_due.delete();
         held_count = 2'd0;
         seq_len = LenInvalid;
      end else begin
         // A byte's words appear in the next cycle at the earliest, so predict first.
         if (req_valid && req_ready) begin
            decode_byte(req_byte, req_end);
         end
         if (rsp_valid && rsp_ready) begin
            if (codepoints_due.size() == 0) begin
               report_mismatch("result word with nothing expected", int'(rsp_codepoint), 0);
            end else begin
               want = codepoints_due.pop_front();
               if (rsp_codepoint !== want.codepoint) begin
                  report_mismatch("codepoint", int'(rsp_codepoint), int'(want.codepoint));
               end
               if (rsp_replaced !== want.replaced) begin
                  report_mismatch("replaced flag", int'(rsp_replaced), int'(want.replaced));
               end
               if (rsp_run_last !== want.run_last) begin
                  report_mismatch("run_last flag", int'(rsp_run_last), int'(want.run_last));
               end
            end
         end
      end
      due_count = codepoints_due.size();
   end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import u8dec_pkg::*;

   localparam int CycleLimit  = 100000;
   localparam int RandomBytes = 350;
   localparam int CalmAfter   = 280;
   localparam int LongHold    = 80;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   words_due;
   int   cycles = 0;
   int   bytes_sent = 0;
   bit   calm = 1'b0;
   bit   flooding = 1'b0;

   // Bit 8 is the stream end flag, bits 7:0 the byte.
   logic [8:0] opening[24] = '{
      9'h000, 9'h07f,                       // ASCII extremes
      9'h0c1, 9'h0bf,                       // overlong two byte lead is accepted
      9'h0ef, 9'h0bf, 9'h0bd,               // genuine U+FFFD, not a replacement
      9'h0f7, 9'h0bf, 9'h0bf, 9'h0bf,       // largest four byte value
      9'h080,                               // lone continuation
      9'h0ff,                               // never valid
      9'h0e2, 9'h082, 9'h041,               // cut by an ASCII byte
      9'h0f0, 9'h090, 9'h180,               // stream ends inside a sequence
      9'h1c3,                               // lead byte carrying stream end
      9'h0f0, 9'h090, 9'h080, 9'h0f8        // three held bytes, then an invalid byte
   };

   u8dec_req_if req_ch();
   u8dec_rsp_if rsp_ch();

   utf8_codepoint_decoder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   u8dec_decode_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_byte      (req_ch.data_byte),
      .req_end       (req_ch.stream_end),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_codepoint (rsp_ch.codepoint),
      .rsp_replaced  (rsp_ch.replaced),
      .rsp_run_last  (rsp_ch.run_last),
      .mismatches    (mismatches),
      .words_due     (words_due)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_byte(input byte_type b, input logic last);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= b;
      req_ch.stream_end <= last;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   function automatic byte_type lead_for(input int len);
      byte_type b;
      case (len)
         1:       b = byte_type'($urandom_range(0, 127));
         2:       b = 8'hc0 | byte_type'($urandom_range(0, 31));
         3:       b = 8'he0 | byte_type'($urandom_range(0, 15));
         default: b = 8'hf0 | byte_type'($urandom_range(0, 7));
      endcase
      return b;
   endfunction

   function automatic byte_type any_continuation();
      return 8'h80 | byte_type'($urandom_range(0, 63));
   endfunction

   // Result side: short random stalls, one long hold once the random part starts.
   initial begin
      bit held_long;
      held_long = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (flooding && !held_long) begin
            held_long = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      int pick;
      int len;
      int cut;
      bit fin;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= '0;
      req_ch.stream_end <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[k]) begin
         send_byte(opening[k][7:0], opening[k][8]);
      end

      flooding = 1'b1;
      while (bytes_sent < $size(opening) + RandomBytes) begin
         if (bytes_sent >= $size(opening) + CalmAfter) begin
            calm = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            // Well-formed sequence with random payload.
            len = $urandom_range(1, 4);
            fin = ($urandom_range(0, 7) == 0);
            send_byte(lead_for(len), fin && len == 1);
            for (int k = 1; k < len; k++) begin
               send_byte(any_continuation(), fin && k == len - 1);
            end
         end else if (pick < 9) begin
            // Sequence broken off early; the next byte, or the stream end, decides how it ends.
            len = $urandom_range(2, 4);
            cut = $urandom_range(1, len - 1);
            fin = ($urandom_range(0, 2) == 0);
            send_byte(lead_for(len), fin && cut == 1);
            for (int k = 1; k < cut; k++) begin
               send_byte(any_continuation(), fin && k == cut - 1);
            end
         end else begin
            send_byte(byte_type'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
         end
      end
      req_ch.valid <= 1'b0;

      do @(posedge clock); while (words_due != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
